// File: rtl/tmtc_pkg.sv
`default_nettype none
package tmtc_pkg;

	// Operand widths of the shared serial arithmetic units.
	localparam int MUL_A_W = 64;
	localparam int MUL_B_W = 48;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 128;
	localparam int DIV_D_W = 64;

	localparam logic [1:0] CMD_APPEND     = 2'd0;
	localparam logic [1:0] CMD_TICK_TO_MS = 2'd1;
	localparam logic [1:0] CMD_MS_TO_TICK = 2'd2;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_REJECT = 2'd1;
	localparam logic [1:0] STATUS_EMPTY  = 2'd2;

	localparam logic REG_TPQ    = 1'b0;
	localparam logic REG_OFFSET = 1'b1;

	localparam logic [15:0] TPQ_RESET       = 16'd480;
	localparam logic [31:0] DEFAULT_BPM_Q16 = 32'd7864320;
	localparam logic [15:0] MS_PER_MINUTE   = 16'd60000;
	localparam logic [46:0] MS_MAX          = '1;
	localparam logic [30:0] TICK_MAX        = '1;
	// 60000 * 2^31 (half a tick in the scaled domain) and 60000 * 2^32.
	localparam logic [63:0] MS_HALF_TICK    = 64'h0000_7530_0000_0000;
	localparam logic [63:0] MS_TO_TICK_DIV  = 64'h0000_EA60_0000_0000;

	// Tempo times resolution; a tempo of zero stands for 120 BPM.
	function automatic logic [47:0] scale_of(input logic [31:0] bpm, input logic [15:0] tpq);
		logic [31:0] eff;
		eff = (bpm == '0) ? DEFAULT_BPM_Q16 : bpm;
		return 48'(eff) * 48'(tpq);
	endfunction

endpackage
`default_nettype wire

// File: rtl/tmtc_mul.sv
`default_nettype none
module tmtc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tmtc_pkg::MUL_A_W-1:0]  a,
	input  logic [tmtc_pkg::MUL_B_W-1:0]  b,
	output logic                          done,
	output logic [tmtc_pkg::MUL_P_W-1:0]  product
);
	import tmtc_pkg::*;

	// Shift-and-add, one multiplier bit per cycle, least significant first.
	logic [MUL_B_W-1:0] hi_q;
	logic [MUL_A_W-1:0] lo_q;
	logic [MUL_B_W-1:0] b_q;
	logic [$clog2(MUL_A_W)-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [MUL_B_W:0] step_sum;

	assign step_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
				hi_q   <= '0;
				lo_q   <= a;
				b_q    <= b;
			end else if (busy_q) begin
				hi_q <= step_sum[MUL_B_W:1];
				lo_q <= {step_sum[0], lo_q[MUL_A_W-1:1]};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule
`default_nettype wire

// File: rtl/tmtc_div.sv
`default_nettype none
module tmtc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tmtc_pkg::DIV_N_W-1:0]  n,
	input  logic [tmtc_pkg::DIV_D_W-1:0]  d,
	output logic                          done,
	output logic [tmtc_pkg::DIV_N_W-1:0]  quotient
);
	import tmtc_pkg::*;

	// Restoring division, one quotient bit per cycle, most significant first.
	// The quotient bits shift into the numerator register as it empties.
	logic [DIV_N_W-1:0] n_q;
	logic [DIV_D_W-1:0] r_q;
	logic [DIV_D_W-1:0] d_q;
	logic [$clog2(DIV_N_W)-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIV_D_W:0] r_shift;
	logic [DIV_D_W:0] r_diff;
	logic fits;

	assign r_shift = {r_q, n_q[DIV_N_W-1]};
	assign r_diff  = r_shift - {1'b0, d_q};
	assign fits    = (r_shift >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
				n_q    <= n;
				r_q    <= '0;
				d_q    <= d;
			end else if (busy_q) begin
				r_q   <= fits ? r_diff[DIV_D_W-1:0] : r_shift[DIV_D_W-1:0];
				n_q   <= {n_q[DIV_N_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = n_q;

endmodule
`default_nettype wire

// File: rtl/tempo_map_tick_time_converter.sv
// Tempo map converter between musical ticks and milliseconds.
// The input stream carries one command per item in s_tuser: append a tempo
// point, convert a tick to milliseconds, or convert milliseconds to a tick.
// Every item gives exactly one result item on the output stream, with the
// status in m_tuser. The configuration channel writes the tick resolution
// (index 0) and the millisecond offset of tick zero (index 1); it is taken
// only while the block is idle, and a resolution write rebuilds the prefix
// table, one point at a time. Items are worked on one at a time. The time
// an item takes is set by the linear scan of the point memory (one entry
// per cycle), the bit-serial multiplier and the bit-serial divider.
// A finished result is held in an output register; the block takes the next
// item while it waits, and only stalls before handing over a second result.
// Reset empties the tempo map and restores a resolution of 480 and an
// offset of zero; the point memories themselves are not cleared.
`default_nettype none
module tempo_map_tick_time_converter #(
	parameter int MAX_POINTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_index, point_tick, point_bpm_q16, query_tick, query_ms, zero pad
	input  logic [151:0] s_tdata,
	// command
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// ms_result, tick_result, zero pad
	output logic [79:0]  m_tdata,
	// status
	output logic [1:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	import tmtc_pkg::*;

	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int CMPW = (CW > 6) ? CW : 6;

	typedef enum logic [4:0] {
		S_IDLE, S_RESTART, S_SCAN, S_SCALE, S_BUILD_GO, S_Q_GO, S_MUL_WAIT,
		S_DIV_GO, S_DIV_WAIT, S_BUILD_END, S_RB_START, S_RB_BASE, S_RB_NEXT,
		S_RB_GET, S_RB_END, S_DONE
	} state_t;

	state_t state_q;

	// Input item fields.
	logic [1:0]  in_cmd;
	logic [5:0]  in_pidx;
	logic [30:0] in_ptick;
	logic [31:0] in_pbpm;
	logic [31:0] in_qtick;
	logic [47:0] in_qms;

	assign in_cmd   = s_tuser;
	assign in_pidx  = s_tdata[5:0];
	assign in_ptick = s_tdata[36:6];
	assign in_pbpm  = s_tdata[68:37];
	assign in_qtick = s_tdata[100:69];
	assign in_qms   = s_tdata[148:101];

	// Configuration and table state.
	logic [15:0]   tpq_q;
	logic [31:0]   offset_q;
	logic [CW-1:0] loaded_q;
	logic [30:0]   last_tick_q;
	logic [31:0]   last_bpm_q;
	logic [63:0]   last_prefix_q;

	// Working registers for the item in progress.
	logic [1:0]    cmd_q;
	logic          rebuild_q;
	logic [CW-1:0] idx_q;
	logic [30:0]   cur_tick_q;
	logic [31:0]   cur_bpm_q;
	logic [63:0]   rem16_q;
	logic [30:0]   base_tick_q;
	logic [31:0]   base_bpm_q;
	logic [63:0]   base_prefix_q;
	logic [47:0]   d_q;
	logic [46:0]   dt60_q;
	logic [MUL_P_W-1:0] acc_q;
	logic [63:0]   new_prefix_q;
	logic [46:0]   res_ms_q;
	logic [30:0]   res_tick_q;
	logic [1:0]    res_status_q;
	logic          scan_vld_s1;
	logic          scan_first_s1;

	// Output register.
	logic          m_tvalid_q;
	logic [46:0]   out_ms_q;
	logic [30:0]   out_tick_q;
	logic [1:0]    out_status_q;

	// Point memories: one write and one registered read per cycle each.
	logic [30:0] tick_mem   [MAX_POINTS];
	logic [31:0] bpm_mem    [MAX_POINTS];
	logic [63:0] prefix_mem [MAX_POINTS];
	logic [30:0] rd_tick_q;
	logic [31:0] rd_bpm_q;
	logic [63:0] rd_prefix_q;

	logic          wr_tick_en;
	logic          wr_prefix_en;
	logic [AW-1:0] wr_addr;
	logic [30:0]   wr_tick;
	logic [63:0]   wr_prefix;
	logic [AW-1:0] rd_addr;

	// Decode of an arriving item.
	logic         in_accept;
	logic         cfg_accept;
	logic         usable;
	logic         append_bad;
	logic signed [48:0] remain;
	logic         rem_pos;
	logic [30:0]  target;

	// Datapath between the units.
	logic         is_tick_q;
	logic         scan_hit;
	logic [64:0]  base_off;
	logic         ms_ovf;
	logic         mul_start;
	logic [MUL_A_W-1:0] mul_a;
	logic         mul_done;
	logic [MUL_P_W-1:0] mul_p;
	logic         div_start;
	logic [DIV_N_W-1:0] div_n;
	logic [DIV_D_W-1:0] div_d;
	logic         div_done;
	logic [DIV_N_W-1:0] div_q;
	logic [64:0]  seg_sum;
	logic [63:0]  build_val;
	logic [46:0]  ms_val;
	logic [31:0]  tick_sum;
	logic [30:0]  tick_val;
	logic [30:0]  dt;

	assign s_tready   = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready  = (state_q == S_IDLE);
	assign in_accept  = s_tvalid && s_tready;
	assign cfg_accept = cfg_valid && cfg_ready;

	assign usable = (loaded_q != '0) && (tpq_q != '0);
	assign append_bad = (CMPW'(in_pidx) != CMPW'(loaded_q)) ||
		(loaded_q >= CW'(MAX_POINTS)) || (in_ptick <= last_tick_q);
	assign remain  = $signed({in_qms[47], in_qms}) - $signed({17'b0, offset_q});
	assign rem_pos = !remain[48] && (remain != '0);
	assign target  = in_qtick[31] ? '0 : in_qtick[30:0];

	assign is_tick_q = (cmd_q == CMD_TICK_TO_MS);

	// The search keeps the last point at or before the key; entry zero always
	// qualifies so that a key before every later point falls back to it.
	assign scan_hit = scan_first_s1 ||
		(is_tick_q ? (rd_tick_q <= cur_tick_q) : (rd_prefix_q <= rem16_q));

	assign dt = cur_tick_q - base_tick_q;

	// Prefix plus offset in Q16 ms; beyond 63 bits the result saturates.
	assign base_off = {1'b0, base_prefix_q} + {17'b0, offset_q, 16'b0};
	assign ms_ovf   = base_off[64] || base_off[63];

	assign mul_start = (state_q == S_Q_GO) && !(is_tick_q && ms_ovf);
	assign mul_a     = is_tick_q ? base_off[63:0] : (rem16_q - base_prefix_q);

	assign div_start = ((state_q == S_BUILD_GO) && (d_q != '0)) || (state_q == S_DIV_GO);

	always_comb begin
		if (state_q == S_BUILD_GO) begin
			div_n = {48'b0, dt60_q, 33'b0} + {80'b0, d_q};
			div_d = {15'b0, d_q, 1'b0};
		end else if (is_tick_q) begin
			div_n = {16'b0, acc_q} + {65'b0, d_q, 15'b0};
			div_d = {d_q, 16'b0};
		end else begin
			div_n = {16'b0, acc_q};
			div_d = MS_TO_TICK_DIV;
		end
	end

	assign seg_sum   = {1'b0, base_prefix_q} + {1'b0, div_q[63:0]};
	assign build_val = ((div_q[127:64] != '0) || seg_sum[64]) ? '1 : seg_sum[63:0];
	assign ms_val    = (div_q[127:47] != '0) ? MS_MAX : div_q[46:0];
	assign tick_sum  = {1'b0, base_tick_q} + {1'b0, div_q[30:0]};
	assign tick_val  = ((div_q[127:31] != '0) || tick_sum[31]) ? TICK_MAX : tick_sum[30:0];

	tmtc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (d_q),
		.done    (mul_done),
		.product (mul_p)
	);

	tmtc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.n        (div_n),
		.d        (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	// Memory ports. The read address follows the scan and rebuild counter.
	assign rd_addr = idx_q[AW-1:0];

	always_comb begin
		wr_tick_en   = 1'b0;
		wr_prefix_en = 1'b0;
		wr_addr      = '0;
		wr_tick      = cur_tick_q;
		wr_prefix    = '0;
		case (state_q)
			S_RESTART: begin
				wr_tick_en   = 1'b1;
				wr_prefix_en = 1'b1;
				wr_tick      = '0;
			end
			S_RB_START: begin
				wr_prefix_en = 1'b1;
			end
			S_BUILD_END: begin
				wr_prefix_en = 1'b1;
				wr_prefix    = new_prefix_q;
				if (rebuild_q) begin
					wr_addr = idx_q[AW-1:0];
				end else begin
					wr_tick_en = 1'b1;
					wr_addr    = loaded_q[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_tick_en) begin
			tick_mem[wr_addr] <= wr_tick;
			bpm_mem[wr_addr]  <= cur_bpm_q;
		end
		if (wr_prefix_en) begin
			prefix_mem[wr_addr] <= wr_prefix;
		end
		rd_tick_q   <= tick_mem[rd_addr];
		rd_bpm_q    <= bpm_mem[rd_addr];
		rd_prefix_q <= prefix_mem[rd_addr];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			tpq_q         <= TPQ_RESET;
			offset_q      <= '0;
			loaded_q      <= '0;
			rebuild_q     <= 1'b0;
			idx_q         <= '0;
			scan_vld_s1   <= 1'b0;
			scan_first_s1 <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			// In the hand-over state the output register is managed below.
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end

			// The entry read in the previous scan cycle is judged here.
			scan_vld_s1   <= (state_q == S_SCAN) && (idx_q < loaded_q);
			scan_first_s1 <= (idx_q == '0);
			if (scan_vld_s1 && scan_hit) begin
				base_tick_q   <= rd_tick_q;
				base_bpm_q    <= rd_bpm_q;
				base_prefix_q <= rd_prefix_q;
			end

			case (state_q)
				S_IDLE: begin
					if (cfg_accept) begin
						if (cfg_index == REG_TPQ) begin
							tpq_q <= cfg_data[15:0];
							if (loaded_q != '0) begin
								cmd_q     <= CMD_APPEND;
								rebuild_q <= 1'b1;
								idx_q     <= '0;
								state_q   <= S_RB_START;
							end
						end else begin
							offset_q <= cfg_data;
						end
					end else if (in_accept) begin
						cmd_q        <= in_cmd;
						rebuild_q    <= 1'b0;
						res_ms_q     <= '0;
						res_tick_q   <= '0;
						res_status_q <= STATUS_OK;
						idx_q        <= '0;
						case (in_cmd)
							CMD_APPEND: begin
								cur_tick_q <= in_ptick;
								cur_bpm_q  <= in_pbpm;
								if (in_pidx == '0) begin
									if (in_ptick != '0) begin
										res_status_q <= STATUS_REJECT;
										state_q      <= S_DONE;
									end else begin
										state_q <= S_RESTART;
									end
								end else if (append_bad) begin
									res_status_q <= STATUS_REJECT;
									state_q      <= S_DONE;
								end else begin
									base_tick_q   <= last_tick_q;
									base_bpm_q    <= last_bpm_q;
									base_prefix_q <= last_prefix_q;
									state_q       <= S_SCALE;
								end
							end
							CMD_TICK_TO_MS: begin
								cur_tick_q <= target;
								if (!usable) begin
									res_ms_q     <= {15'b0, offset_q};
									res_status_q <= STATUS_EMPTY;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							CMD_MS_TO_TICK: begin
								rem16_q <= {1'b0, remain[46:0], 16'b0};
								if (!usable) begin
									res_status_q <= STATUS_EMPTY;
									state_q      <= S_DONE;
								end else if (!rem_pos) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								res_status_q <= STATUS_REJECT;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_RESTART: begin
					loaded_q      <= CW'(1);
					last_tick_q   <= '0;
					last_bpm_q    <= cur_bpm_q;
					last_prefix_q <= '0;
					state_q       <= S_DONE;
				end
				S_SCAN: begin
					if (idx_q < loaded_q) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					d_q    <= scale_of(base_bpm_q, tpq_q);
					dt60_q <= 47'(dt) * 47'(MS_PER_MINUTE);
					state_q <= (cmd_q == CMD_APPEND) ? S_BUILD_GO : S_Q_GO;
				end
				S_BUILD_GO: begin
					if (d_q == '0) begin
						// No tempo scale: the segment adds no time.
						new_prefix_q <= base_prefix_q;
						state_q      <= S_BUILD_END;
					end else begin
						state_q <= S_DIV_WAIT;
					end
				end
				S_Q_GO: begin
					if (is_tick_q && ms_ovf) begin
						res_ms_q <= MS_MAX;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_MUL_WAIT;
					end
				end
				S_MUL_WAIT: begin
					if (mul_done) begin
						acc_q <= mul_p + (is_tick_q ? {33'b0, dt60_q, 32'b0}
							: {48'b0, MS_HALF_TICK});
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						case (cmd_q)
							CMD_APPEND: begin
								new_prefix_q <= build_val;
								state_q      <= S_BUILD_END;
							end
							CMD_TICK_TO_MS: begin
								res_ms_q <= ms_val;
								state_q  <= S_DONE;
							end
							default: begin
								res_tick_q <= tick_val;
								state_q    <= S_DONE;
							end
						endcase
					end
				end
				S_BUILD_END: begin
					if (rebuild_q) begin
						base_tick_q   <= cur_tick_q;
						base_bpm_q    <= cur_bpm_q;
						base_prefix_q <= new_prefix_q;
						idx_q         <= idx_q + 1'b1;
						state_q       <= S_RB_NEXT;
					end else begin
						last_tick_q   <= cur_tick_q;
						last_bpm_q    <= cur_bpm_q;
						last_prefix_q <= new_prefix_q;
						loaded_q      <= loaded_q + 1'b1;
						state_q       <= S_DONE;
					end
				end
				S_RB_START: begin
					state_q <= S_RB_BASE;
				end
				S_RB_BASE: begin
					base_tick_q   <= rd_tick_q;
					base_bpm_q    <= rd_bpm_q;
					base_prefix_q <= '0;
					idx_q         <= CW'(1);
					state_q       <= S_RB_NEXT;
				end
				S_RB_NEXT: begin
					state_q <= (idx_q >= loaded_q) ? S_RB_END : S_RB_GET;
				end
				S_RB_GET: begin
					cur_tick_q <= rd_tick_q;
					cur_bpm_q  <= rd_bpm_q;
					state_q    <= S_SCALE;
				end
				S_RB_END: begin
					last_prefix_q <= base_prefix_q;
					rebuild_q     <= 1'b0;
					state_q       <= S_IDLE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q   <= 1'b1;
						out_ms_q     <= res_ms_q;
						out_tick_q   <= res_tick_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b0, out_tick_q, out_ms_q};
	assign m_tuser  = out_status_q;

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import tmtc_pkg::*;

	// The fourth command code is unused by the block and must be refused.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// Cycles without any handshake on any channel before the run is declared hung.
	// A resolution write over a full table rebuilds every point while no channel moves.
	localparam int STALL_LIMIT = 40000;
	localparam int LONG_HOLD   = 1500;

	typedef struct {
		logic [1:0]         cmd;
		logic [5:0]         idx;
		logic [30:0]        ptick;
		logic [31:0]        bpm;
		logic signed [31:0] qtick;
		logic signed [47:0] qms;
	} tm_item_t;

	typedef struct {
		logic [46:0] ms;
		logic [30:0] tick;
		logic [1:0]  status;
	} tm_result_t;

	// Keeps its own copy of the tempo map and the registers, works out the result of
	// every accepted item and checks the results in order.
	class tempo_scoreboard;
		bit [15:0]  tpq;
		bit [31:0]  offset;
		bit [30:0]  starts[64];
		bit [31:0]  bpms[64];
		bit [63:0]  prefix[64];
		int         loaded;
		tm_result_t pending[$];
		int         errors;

		function new();
			tpq = TPQ_RESET;
			offset = 0;
			loaded = 0;
			errors = 0;
		endfunction

		function bit [63:0] tempo_scale(int i);
			bit [63:0] b;
			b = (bpms[i] == 0) ? 64'(DEFAULT_BPM_Q16) : 64'(bpms[i]);
			return b * tpq;
		endfunction

		// Duration of the segment before point i, added to the running time in Q48.16 ms.
		function void extend_prefix(int i);
			bit [63:0]  d;
			bit [63:0]  dt;
			bit [127:0] num;
			bit [127:0] seg;
			bit [64:0]  sum;
			d = tempo_scale(i - 1);
			dt = 64'(starts[i] - starts[i - 1]);
			if (d == 0) begin
				prefix[i] = prefix[i - 1];
				return;
			end
			num = ((128'(dt) * 128'(60000)) << 33) + 128'(d);
			seg = num / (128'(d) << 1);
			sum = 65'(prefix[i - 1]) + 65'(seg[63:0]);
			prefix[i] = (seg[127:64] != 0 || sum[64]) ? '1 : sum[63:0];
		endfunction

		function void configure(logic idx, logic [31:0] v);
			if (idx == REG_TPQ) begin
				tpq = v[15:0];
				if (loaded > 0) prefix[0] = 0;
				for (int i = 1; i < loaded; i++) extend_prefix(i);
			end else begin
				offset = v;
			end
		endfunction

		function void note(tm_item_t it);
			tm_result_t r;
			bit         usable;
			int         seg_i;
			bit [63:0]  target, off16, d, dt, rem16, into, t;
			bit [127:0] num, q;
			longint     remain;
			r.ms = 0;
			r.tick = 0;
			r.status = STATUS_OK;
			usable = loaded > 0 && tpq != 0;
			case (it.cmd)
				CMD_APPEND: begin
					if (it.idx == 0) begin
						if (it.ptick != 0) r.status = STATUS_REJECT;
						else begin
							starts[0] = 0;
							bpms[0] = it.bpm;
							prefix[0] = 0;
							loaded = 1;
						end
					end else if (it.idx != loaded || loaded >= 64 ||
							it.ptick <= starts[it.idx - 1]) begin
						r.status = STATUS_REJECT;
					end else begin
						starts[it.idx] = it.ptick;
						bpms[it.idx] = it.bpm;
						extend_prefix(it.idx);
						loaded = it.idx + 1;
					end
				end
				CMD_TICK_TO_MS: begin
					if (!usable) begin
						r.ms = 47'(offset);
						r.status = STATUS_EMPTY;
					end else begin
						target = it.qtick[31] ? 64'd0 : 64'(it.qtick);
						off16 = 64'(offset) << 16;
						seg_i = 0;
						for (int k = 1; k < loaded; k++)
							if (starts[k] <= target) seg_i = k;
						if (prefix[seg_i] > 64'h7FFF_FFFF_FFFF_FFFF - off16) begin
							r.ms = MS_MAX;
						end else begin
							d = tempo_scale(seg_i);
							dt = target - starts[seg_i];
							num = 128'(off16 + prefix[seg_i]) * 128'(d)
								+ ((128'(dt) * 128'(60000)) << 32) + (128'(d) << 15);
							q = num / (128'(d) << 16);
							r.ms = (q > 128'(MS_MAX)) ? MS_MAX : q[46:0];
						end
					end
				end
				CMD_MS_TO_TICK: begin
					if (!usable) begin
						r.status = STATUS_EMPTY;
					end else begin
						remain = longint'(it.qms) - longint'({32'd0, offset});
						if (remain > 0) begin
							rem16 = 64'(remain) << 16;
							seg_i = 0;
							for (int k = 1; k < loaded; k++)
								if (prefix[k] <= rem16) seg_i = k;
							into = rem16 - prefix[seg_i];
							num = 128'(into) * 128'(tempo_scale(seg_i)) + (128'(60000) << 31);
							q = num / (128'(60000) << 32);
							if (q > 128'(TICK_MAX)) r.tick = TICK_MAX;
							else begin
								t = 64'(starts[seg_i]) + q[63:0];
								r.tick = (t > 64'(TICK_MAX)) ? TICK_MAX : t[30:0];
							end
						end
					end
				end
				default: r.status = STATUS_REJECT;
			endcase
			pending = {pending, r};
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
			errors++;
		endtask

		task check(tm_result_t got);
			tm_result_t want;
			if (pending.size() == 0) begin
				report("unexpected result item", 64'(got.status), 0);
				return;
			end
			want = pending.pop_front();
			if (got.ms !== want.ms) report("ms_result", 64'(got.ms), 64'(want.ms));
			if (got.tick !== want.tick) report("tick_result", 64'(got.tick), 64'(want.tick));
			if (got.status !== want.status)
				report("status", 64'(got.status), 64'(want.status));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [79:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [31:0]  cfg_data;

	tempo_scoreboard sb;
	// When set, neither side inserts gaps, so the block sees back-to-back traffic.
	bit no_idle;
	int results_seen;
	int stall_count;

	tempo_map_tick_time_converter DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Gaps are mostly absent or short, with the occasional long one.
	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Receiver: takes results, checks them, and once holds off for a long stretch
	// so that the result register fills and the block stops taking items.
	initial begin
		bit held;
		tm_result_t got;
		held = 0;
		results_seen = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.ms = m_tdata[46:0];
				got.tick = m_tdata[77:47];
				got.status = m_tuser;
				sb.check(got);
				results_seen++;
			end
			if (!held && results_seen == 150) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			m_tready <= (pick_gap() == 0);
		end
	end

	// Watchdog on cycles in which no channel moves anything.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_count <= 0;
		else begin
			stall_count <= stall_count + 1;
			if (stall_count == STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic send(tm_item_t it);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {3'b000, it.qms, it.qtick, it.bpm, it.ptick, it.idx};
		do @(posedge clk); while (!s_tready);
		sb.note(it);
	endtask

	// The sender stops and waits for every outstanding result.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// Registers are written only while the block has nothing in flight.
	task automatic write_reg(logic idx, logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.configure(idx, v);
		@(posedge clk);
	endtask

	function automatic tm_item_t any_item();
		tm_item_t it;
		it.cmd = 2'($urandom_range(0, 3));
		it.idx = 6'($urandom);
		it.ptick = 31'($urandom);
		it.bpm = $urandom;
		it.qtick = $urandom;
		it.qms = 48'({$urandom, $urandom});
		return it;
	endfunction

	function automatic tm_item_t mk(logic [1:0] cmd, logic [5:0] idx, logic [30:0] ptick,
			logic [31:0] bpm, logic [31:0] qtick, logic [47:0] qms);
		tm_item_t it;
		it = any_item();
		it.cmd = cmd;
		it.idx = idx;
		it.ptick = ptick;
		it.bpm = bpm;
		it.qtick = qtick;
		it.qms = qms;
		return it;
	endfunction

	function automatic logic [31:0] pick_bpm();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r < 7) return $urandom_range(40 << 16, 300 << 16);
		return $urandom;
	endfunction

	// A well-formed table: restart at tick zero, then strictly rising ticks.
	task automatic build_table(int n);
		tm_item_t it;
		longint last, step, room;
		it = any_item();
		it.cmd = CMD_APPEND;
		it.idx = 0;
		it.ptick = 0;
		it.bpm = pick_bpm();
		send(it);
		last = 0;
		for (int k = 1; k < n; k++) begin
			room = longint'(TICK_MAX) - last;
			if (room < n - k) break;
			step = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4000)
				: $urandom_range(1, 1 << 28);
			if (step > room / (n - k)) step = room / (n - k);
			if (step < 1) step = 1;
			last += step;
			it = any_item();
			it.cmd = CMD_APPEND;
			it.idx = 6'(k);
			it.ptick = 31'(last);
			it.bpm = pick_bpm();
			send(it);
		end
	endtask

	task automatic send_query();
		tm_item_t it;
		int r;
		int top;
		it = any_item();
		r = $urandom_range(0, 99);
		top = (sb.loaded > 0) ? sb.loaded - 1 : 0;
		if ($urandom_range(0, 1)) begin
			it.cmd = CMD_TICK_TO_MS;
			if (r < 30) it.qtick = $urandom;
			else if (r < 50) it.qtick = sb.starts[$urandom_range(0, top)];
			else it.qtick = sb.starts[top] + $urandom_range(0, 20000);
		end else begin
			it.cmd = CMD_MS_TO_TICK;
			if (r < 25) it.qms = 48'({$urandom, $urandom});
			else if (r < 35) it.qms = 48'(sb.offset) - 48'($urandom_range(0, 1));
			else if (r < 70) it.qms = 48'(sb.offset) + 48'($urandom_range(1, 1 << 24));
			else it.qms = 48'(sb.offset) + 48'({$urandom_range(0, 255), $urandom});
		end
		send(it);
	endtask

	// Broken and stray items: wrong slot, ticks that do not rise, bad restarts, junk.
	task automatic send_noise();
		tm_item_t it;
		int r;
		it = any_item();
		r = $urandom_range(0, 3);
		if (r == 1 && sb.loaded > 0 && sb.loaded < 64) begin
			it.cmd = CMD_APPEND;
			it.idx = 6'(sb.loaded);
			it.ptick = sb.starts[sb.loaded - 1] - 31'($urandom_range(0, 3));
		end else if (r == 2) begin
			it.cmd = CMD_APPEND;
			it.idx = 0;
			it.ptick = 31'($urandom_range(1, 32'h7FFF_FFFF));
		end else if (r == 3) begin
			it.cmd = CMD_UNUSED;
		end
		send(it);
	endtask

	task automatic run_phase(int n, int table_max);
		int stop;
		stop = $urandom_range(0, 2) == 0;
		no_idle = 0;
		for (int done = 0; done < n; done++) begin
			if (done == n / 2) no_idle = stop;
			if (sb.loaded == 0 || $urandom_range(0, 99) < 8)
				build_table($urandom_range(0, 9) == 0 ? table_max : $urandom_range(1, 8));
			else if ($urandom_range(0, 99) < 15)
				send_noise();
			else
				send_query();
		end
		no_idle = 0;
	endtask

	initial begin
		sb = new();
		no_idle = 0;
		stall_count = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TPQ;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset settings: empty table, refused writes, a map
		// with the slowest, fastest and default tempos and the widest ticks, then
		// queries at the clamps and saturation limits.
		send(mk(CMD_TICK_TO_MS, 0, 0, 0, 100, 0));
		send(mk(CMD_MS_TO_TICK, 0, 0, 0, 0, 48'd5000));
		send(mk(CMD_UNUSED, 0, 0, 0, 0, 0));
		send(mk(CMD_APPEND, 5, 100, 0, 0, 0));
		send(mk(CMD_APPEND, 0, 7, 0, 0, 0));
		send(mk(CMD_APPEND, 0, 0, 0, 0, 0));
		send(mk(CMD_APPEND, 1, 0, 0, 0, 0));
		send(mk(CMD_APPEND, 1, 480, 32'hFFFF_FFFF, 0, 0));
		send(mk(CMD_APPEND, 2, 960, 1, 0, 0));
		send(mk(CMD_APPEND, 3, TICK_MAX, 60 << 16, 0, 0));
		send(mk(CMD_TICK_TO_MS, 0, 0, 0, 32'hFFFF_FFFF, 0));
		send(mk(CMD_TICK_TO_MS, 0, 0, 0, 32'h8000_0000, 0));
		send(mk(CMD_TICK_TO_MS, 0, 0, 0, 0, 0));
		send(mk(CMD_TICK_TO_MS, 0, 0, 0, 32'h7FFF_FFFF, 0));
		send(mk(CMD_TICK_TO_MS, 0, 0, 0, 967, 0));
		send(mk(CMD_MS_TO_TICK, 0, 0, 0, 0, 0));
		send(mk(CMD_MS_TO_TICK, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF));
		send(mk(CMD_MS_TO_TICK, 0, 0, 0, 0, 48'h8000_0000_0000));
		send(mk(CMD_MS_TO_TICK, 0, 0, 0, 0, 48'h7FFF_FFFF_FFFF));
		send(mk(CMD_MS_TO_TICK, 0, 0, 0, 0, 48'd500));
		send(mk(CMD_MS_TO_TICK, 0, 0, 0, 0, 48'd1000000));
		send(mk(CMD_APPEND, 0, 0, DEFAULT_BPM_Q16, 0, 0));
		send(mk(CMD_APPEND, 2, 50, 0, 0, 0));
		send(mk(CMD_MS_TO_TICK, 0, 0, 0, 0, 48'd1));

		// Random phases, each under its own register settings; resolution writes
		// land on a loaded table and so exercise the rebuild.
		write_reg(REG_TPQ, TPQ_RESET);
		write_reg(REG_OFFSET, 0);
		run_phase(45, 8);
		write_reg(REG_TPQ, 1);
		write_reg(REG_OFFSET, 32'hFFFF_FFFF);
		run_phase(45, 16);
		write_reg(REG_TPQ, 16'hFFFF);
		write_reg(REG_OFFSET, 0);
		build_table(64);
		run_phase(45, 64);
		write_reg(REG_TPQ, $urandom_range(1, 65535));
		write_reg(REG_OFFSET, $urandom);
		run_phase(45, 12);
		write_reg(REG_TPQ, 960);
		write_reg(REG_OFFSET, 1000);
		run_phase(45, 8);
		write_reg(REG_TPQ, $urandom_range(1, 2000));
		write_reg(REG_OFFSET, $urandom_range(0, 100000));
		run_phase(45, 8);

		drain();
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
